[sv/rpwe_pkg.sv]
package rpwe_pkg;

  localparam int POS_W   = 12;
  localparam int WIN_W   = POS_W + 1;
  localparam int IN_VAL_W = 12;
  localparam int CNT_W   = 13;
  localparam int TAG_W   = 16;
  localparam int SUM_W   = 36;
  localparam int CFG_W   = 13;

  localparam int DEFAULT_ELEMENT_DEPTH = 4096;
  localparam int DEFAULT_VALUE_BITS    = 12;

  localparam logic [CFG_W-1:0] ELEMENT_COUNT_RESET = CFG_W'(4096);
  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(1) << POS_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // control from the sequencer to the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic drop;
  } sum_ctl_t;

endpackage

[sv/rpwe_sum_unit.sv]
module rpwe_sum_unit import rpwe_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sum_ctl_t              ctl,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [CNT_W-1:0]      count,
  output logic [SUM_W-1:0]      sum
);

  localparam int FAC_W  = CNT_W + 1;
  localparam int PROD_W = FAC_W + VALUE_BITS;

  logic [FAC_W-1:0]  factor;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              drop_r, drop_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // (c+1)^2 - c^2 = 2c+1, c^2 - (c-1)^2 = 2c-1
  always_comb begin
    if (ctl.drop) begin
      factor = {count, 1'b0} - FAC_W'(1);
    end else begin
      factor = {count, 1'b0} + FAC_W'(1);
    end
  end

  always_comb begin
    prod_nxt = prod_r;
    drop_nxt = drop_r;
    if (ctl.mul_en) begin
      prod_nxt = PROD_W'(factor) * PROD_W'(value);
      drop_nxt = ctl.drop;
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.acc_en) begin
      if (drop_r) begin
        sum_nxt = sum_r - SUM_W'(prod_r);
      end else begin
        sum_nxt = sum_r + SUM_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    drop_r <= drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

[sv/range_power_window_engine_core.sv]
// channel | direction | handshake                | payload
// in      | slave     | in_tvalid / in_tready    | tuser req_type, tdata load/query fields
// out     | master    | out_tvalid / out_tready  | tuser bad_range, tdata tag and power
// cfg     | slave     | cfg_valid / cfg_ready    | cfg_data element_count
//
// a query moves its window edges one position at a time, each move going through edge step,
// element read, count read, multiply and count write, and accumulate through the one
// multiply-accumulate unit, the last two skipped for a drop of a zero count; a rejected query
// goes straight to its result; a load walks the elements left in the window, zeroing their
// counts, then writes the element; after reset the count table is swept to zero, in_tready low
// in_tready is high only between items; a result waits in the output register
module range_power_window_engine_core import rpwe_pkg::*; #(
  parameter int ELEMENT_DEPTH = DEFAULT_ELEMENT_DEPTH,
  parameter int VALUE_BITS    = DEFAULT_VALUE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // position, element_value, range_left, range_right, query_tag
  input  logic             in_tuser,   // req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,  // answer_tag, range_power, zero fill
  output logic             out_tuser,  // bad_range
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;

  localparam logic [3:0] ST_INIT    = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_START   = 4'd2;
  localparam logic [3:0] ST_WALK_RD = 4'd3;
  localparam logic [3:0] ST_WALK_WR = 4'd4;
  localparam logic [3:0] ST_LOAD_WR = 4'd5;
  localparam logic [3:0] ST_PLAN    = 4'd6;
  localparam logic [3:0] ST_ELEM    = 4'd7;
  localparam logic [3:0] ST_CNT     = 4'd8;
  localparam logic [3:0] ST_MUL     = 4'd9;
  localparam logic [3:0] ST_ACC     = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [VALUE_BITS-1:0] elem_mem [ELEMENT_DEPTH];
  logic [CNT_W-1:0]      cnt_mem  [2**VALUE_BITS];

  logic [3:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] init_idx_r, init_idx_nxt;
  logic [WIN_W-1:0]      ws_r, ws_nxt;
  logic [WIN_W-1:0]      we_r, we_nxt;
  logic [WIN_W-1:0]      mv_pos_r, mv_pos_nxt;
  logic                  drop_r, drop_nxt;
  logic                  bad_r, bad_nxt;
  logic [CFG_W-1:0]      elem_count_r;

  logic                  req_r;
  logic [POS_W-1:0]      pos_r, left_r, right_r;
  logic [IN_VAL_W-1:0]   val_r;
  logic [TAG_W-1:0]      tag_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]      out_tag_r;
  logic [SUM_W-1:0]      out_pow_r;
  logic                  out_bad_r;
  logic                  out_load;

  logic [VALUE_BITS-1:0] elem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [AW-1:0]         elem_raddr;
  logic                  elem_we;
  logic                  cnt_we;
  logic [VALUE_BITS-1:0] cnt_waddr;
  logic [CNT_W-1:0]      cnt_wdata;

  logic [WIN_W-1:0]      left_w, stop_w;
  logic                  query_bad;
  logic                  skip_drop;
  logic                  in_xfer;
  sum_ctl_t              sum_ctl;
  logic [SUM_W-1:0]      sum;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign left_w = {1'b0, left_r};
  assign stop_w = {1'b0, right_r} + WIN_W'(1);

  assign query_bad = (left_r > right_r) ||
                     ({{(32-POS_W){1'b0}}, right_r} >= {{(32-CFG_W){1'b0}}, elem_count_r}) ||
                     ({{(32-POS_W){1'b0}}, right_r} >= 32'(ELEMENT_DEPTH));

  // a drop of a value whose count is already zero leaves the count and the sum alone
  assign skip_drop = drop_r && (cnt_q == '0);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    init_idx_nxt = init_idx_r;
    ws_nxt       = ws_r;
    we_nxt       = we_r;
    mv_pos_nxt   = mv_pos_r;
    drop_nxt     = drop_r;
    bad_nxt      = bad_r;
    sum_ctl      = '0;
    case (state_r)
      ST_INIT: begin
        init_idx_nxt = init_idx_r + VALUE_BITS'(1);
        if (init_idx_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (req_r == REQ_LOAD) begin
          state_nxt = (ws_r == we_r) ? ST_LOAD_WR : ST_WALK_RD;
        end else if (query_bad) begin
          bad_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          bad_nxt   = 1'b0;
          if (ws_r == we_r) begin
            ws_nxt = left_w;
            we_nxt = left_w;
          end
          state_nxt = ST_PLAN;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        ws_nxt    = ws_r + WIN_W'(1);
        state_nxt = (ws_r + WIN_W'(1) == we_r) ? ST_LOAD_WR : ST_WALK_RD;
      end
      ST_LOAD_WR: begin
        ws_nxt        = '0;
        we_nxt        = '0;
        sum_ctl.clear = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_PLAN: begin
        // grow before shrinking so no count goes below zero
        if (ws_r > left_w) begin
          mv_pos_nxt = ws_r - WIN_W'(1);
          ws_nxt     = ws_r - WIN_W'(1);
          drop_nxt   = 1'b0;
          state_nxt  = ST_ELEM;
        end else if (we_r < stop_w) begin
          mv_pos_nxt = we_r;
          we_nxt     = we_r + WIN_W'(1);
          drop_nxt   = 1'b0;
          state_nxt  = ST_ELEM;
        end else if (ws_r < left_w) begin
          mv_pos_nxt = ws_r;
          ws_nxt     = ws_r + WIN_W'(1);
          drop_nxt   = 1'b1;
          state_nxt  = ST_ELEM;
        end else if (we_r > stop_w) begin
          mv_pos_nxt = we_r - WIN_W'(1);
          we_nxt     = we_r - WIN_W'(1);
          drop_nxt   = 1'b1;
          state_nxt  = ST_ELEM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ELEM: begin
        state_nxt = ST_CNT;
      end
      ST_CNT: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        sum_ctl.mul_en = !skip_drop;
        sum_ctl.drop   = drop_r;
        state_nxt      = skip_drop ? ST_PLAN : ST_ACC;
      end
      ST_ACC: begin
        sum_ctl.acc_en = 1'b1;
        state_nxt      = ST_PLAN;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_idx_r   <= '0;
      ws_r         <= '0;
      we_r         <= '0;
      elem_count_r <= ELEMENT_COUNT_RESET;
    end else begin
      state_r    <= state_nxt;
      init_idx_r <= init_idx_nxt;
      ws_r       <= ws_nxt;
      we_r       <= we_nxt;
      if (cfg_valid && cfg_ready) begin
        elem_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mv_pos_r <= mv_pos_nxt;
    drop_r   <= drop_nxt;
    bad_r    <= bad_nxt;
    if (in_xfer) begin
      req_r   <= in_tuser;
      pos_r   <= in_tdata[11:0];
      val_r   <= in_tdata[23:12];
      left_r  <= in_tdata[35:24];
      right_r <= in_tdata[47:36];
      tag_r   <= in_tdata[63:48];
    end
  end

  // element store
  assign elem_raddr = (state_r == ST_WALK_RD) ? AW'(ws_r) : AW'(mv_pos_r);
  assign elem_we    = (state_r == ST_LOAD_WR) &&
                      ({{(32-POS_W){1'b0}}, pos_r} < 32'(ELEMENT_DEPTH));

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[AW'(pos_r)] <= VALUE_BITS'(val_r);
    end
    elem_q <= elem_mem[elem_raddr];
  end

  // count table
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = elem_q;
    cnt_wdata = '0;
    case (state_r)
      ST_INIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = init_idx_r;
      end
      ST_WALK_WR: begin
        cnt_we = 1'b1;
      end
      ST_MUL: begin
        cnt_we    = !skip_drop;
        cnt_wdata = drop_r ? cnt_q - CNT_W'(1) : cnt_q + CNT_W'(1);
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[elem_q];
  end

  rpwe_sum_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_sum (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (sum_ctl),
    .value(elem_q),
    .count(cnt_q),
    .sum  (sum)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tag_r <= tag_r;
      out_pow_r <= bad_r ? '0 : sum;
      out_bad_r <= bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_pow_r, out_tag_r};
  assign out_tuser  = out_bad_r;

  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ws_r <= we_r)
    else $error("window start passed window end");

  a_window_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    we_r <= WIN_MAX)
    else $error("window end beyond position range");

  a_bad_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[51:16] == '0)
    else $error("rejected query carries a nonzero power");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after an accepted item");

endmodule

[tb/range_power_window_engine_core_test.sv]
`timescale 1ns / 1ps

// predicts answers and checks them in order of arrival
class range_power_checker;
  typedef struct packed {
    logic [15:0] tag;
    logic [35:0] power;
    logic        bad;
  } answer_t;

  logic [11:0] element_store [4096];
  bit          loaded [4096];
  logic [12:0] value_count [4096];
  logic [35:0] power_sum;
  int          win_lo;
  int          win_hi;
  logic [12:0] element_limit;
  answer_t     pending_answers [$];
  int          mismatches;
  int          answers_seen;
  int          loads_seen;
  int          queries_seen;
  int          rejects_seen;

  function new();
    foreach (element_store[i]) begin
      element_store[i] = '0;
      loaded[i] = 1'b0;
      value_count[i] = '0;
    end
    power_sum = '0;
    win_lo = 0;
    win_hi = 0;
    element_limit = rpwe_pkg::ELEMENT_COUNT_RESET;
    mismatches = 0;
    answers_seen = 0;
    loads_seen = 0;
    queries_seen = 0;
    rejects_seen = 0;
  endfunction

  function void set_limit(logic [12:0] value);
    element_limit = value;
  endfunction

  function int query_limit();
    return (element_limit > rpwe_pkg::WIN_MAX) ? int'(rpwe_pkg::WIN_MAX) : int'(element_limit);
  endfunction

  function bit accepts(int left, int right);
    return (left <= right) && (right < query_limit());
  endfunction

  // every position the edge walk could touch must hold a loaded element
  function bit span_loaded(int left, int right);
    int lo;
    int hi;
    lo = left;
    hi = right;
    if (win_lo != win_hi) begin
      if (win_lo < lo) lo = win_lo;
      if (win_hi - 1 > hi) hi = win_hi - 1;
    end
    for (int p = lo; p <= hi; p++) begin
      if (!loaded[p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void empty_window();
    foreach (value_count[i]) value_count[i] = '0;
    power_sum = '0;
    win_lo = 0;
    win_hi = 0;
  endfunction

  // (c+1)^2 - c^2 = 2c+1
  function void add_element(int p);
    logic [11:0] v;
    longint unsigned c;
    v = element_store[p];
    c = value_count[v];
    power_sum = power_sum + 36'((2 * c + 1) * v);
    value_count[v] = 13'(c + 1);
  endfunction

  function void remove_element(int p);
    logic [11:0] v;
    longint unsigned c;
    v = element_store[p];
    c = value_count[v];
    if (c == 0) return;
    power_sum = power_sum - 36'((2 * c - 1) * v);
    value_count[v] = 13'(c - 1);
  endfunction

  function void note_request(logic req, logic [11:0] pos, logic [11:0] val,
                             logic [11:0] left, logic [11:0] right, logic [15:0] tag);
    answer_t a;
    int lo;
    int stop;
    if (req == rpwe_pkg::REQ_LOAD) begin
      element_store[pos] = val;
      loaded[pos] = 1'b1;
      empty_window();
      loads_seen++;
      return;
    end
    queries_seen++;
    a.tag = tag;
    if (!accepts(int'(left), int'(right))) begin
      a.power = '0;
      a.bad = 1'b1;
      rejects_seen++;
    end else begin
      lo = int'(left);
      stop = int'(right) + 1;
      if (win_lo == win_hi) begin
        win_lo = lo;
        win_hi = lo;
      end
      // grow before shrinking so no count underflows
      while (win_lo > lo) begin
        win_lo--;
        add_element(win_lo);
      end
      while (win_hi < stop) begin
        add_element(win_hi);
        win_hi++;
      end
      while (win_lo < lo) begin
        remove_element(win_lo);
        win_lo++;
      end
      while (win_hi > stop) begin
        win_hi--;
        remove_element(win_hi);
      end
      a.power = power_sum;
      a.bad = 1'b0;
    end
    pending_answers.push_back(a);
  endfunction

  function void check_answer(logic [15:0] tag, logic [35:0] power, logic bad, logic [3:0] fill);
    answer_t want;
    if (pending_answers.size() == 0) begin
      if (mismatches < 10)
        $display("answer with no query outstanding: tag %h power %0d bad %b", tag, power, bad);
      mismatches++;
      return;
    end
    want = pending_answers.pop_front();
    if (tag !== want.tag || power !== want.power || bad !== want.bad || fill !== 4'h0) begin
      if (mismatches < 10)
        $display("answer %0d wrong: expected tag %h power %0d bad %b, got tag %h power %0d bad %b fill %h",
                 answers_seen, want.tag, want.power, want.bad, tag, power, bad, fill);
      mismatches++;
    end
    answers_seen++;
  endfunction
endclass

module range_power_window_engine_core_test import rpwe_pkg::*;;

  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int LOAD_DRAIN      = 3 + 2 * int'(WIN_MAX) + 16;
  localparam int ITEMS_PER_PHASE = 84;

  typedef struct packed {
    logic        req;
    logic [11:0] pos;
    logic [11:0] val;
    logic [11:0] left;
    logic [11:0] right;
    logic [15:0] tag;
  } item_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [63:0]      in_tdata;   // position, element_value, range_left, range_right, query_tag
  logic             in_tuser;   // req_type
  logic             out_tvalid;
  logic             out_tready;
  logic [55:0]      out_tdata;  // answer_tag, range_power, zero fill
  logic             out_tuser;  // bad_range
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  range_power_checker sb = new();

  int          fill_top = 0;   // positions below this are all loaded
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int          idle_cycles = 0;
  int unsigned limit_plan [7] = '{1, 37, 4096, 0, 8191, 300, 4096};

  range_power_window_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [11:0] pick_value();
    case ($urandom_range(0, 2))
      0: return 12'($urandom_range(0, 7));
      1: return 12'($urandom_range(0, 4095));
      default: begin
        case ($urandom_range(0, 3))
          0: return 12'd0;
          1: return 12'd1;
          2: return 12'd2048;
          default: return 12'd4095;
        endcase
      end
    endcase
  endfunction

  function automatic item_t load_item(int pos, int val);
    item_t it;
    it.req = REQ_LOAD;
    it.pos = 12'(pos);
    it.val = 12'(val);
    it.left = 12'($urandom);
    it.right = 12'($urandom);
    it.tag = 16'($urandom);
    return it;
  endfunction

  function automatic item_t query_item(int left, int right, int tag);
    item_t it;
    it.req = REQ_QUERY;
    it.pos = 12'($urandom);
    it.val = 12'($urandom);
    it.left = 12'(left);
    it.right = 12'(right);
    it.tag = 16'(tag);
    return it;
  endfunction

  // mostly small edge moves around the current window, as a sorted query stream would give
  function automatic item_t pick_item();
    item_t it;
    int r;
    int hi_lim;
    int lo;
    int hi;
    int t;
    r = $urandom_range(0, 99);
    hi_lim = sb.query_limit();
    if (hi_lim > fill_top) hi_lim = fill_top;
    if (r < 14) begin
      it = load_item(0, pick_value());
      t = $urandom_range(0, 99);
      if (t < 60 && fill_top < 4096) begin
        it.pos = 12'(fill_top);
        fill_top++;
      end else if (t < 85) begin
        it.pos = 12'($urandom_range(0, fill_top - 1));
      end else begin
        it.pos = 12'($urandom_range(0, 4095));
      end
      return it;
    end
    it = query_item($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535));
    if (r >= 32 && hi_lim > 0) begin
      if (sb.win_lo == sb.win_hi || r >= 90) begin
        lo = $urandom_range(0, hi_lim - 1);
        hi = lo + $urandom_range(0, (r >= 95) ? 63 : 15);
      end else begin
        lo = sb.win_lo + int'($urandom_range(0, 12)) - 6;
        hi = sb.win_hi - 1 + int'($urandom_range(0, 12)) - 6;
      end
      if (lo < 0) lo = 0;
      if (hi < 0) hi = 0;
      if (lo > hi_lim - 1) lo = hi_lim - 1;
      if (hi > hi_lim - 1) hi = hi_lim - 1;
      if (lo > hi) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      it.left = 12'(lo);
      it.right = 12'(hi);
    end
    // a reachable range over unloaded positions becomes a reload, which also empties the window
    if (sb.accepts(int'(it.left), int'(it.right)) && !sb.span_loaded(int'(it.left), int'(it.right)))
      it = load_item($urandom_range(0, fill_top - 1), pick_value());
    return it;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input item_t it);
    if (!steady && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 9);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.req;
    in_tdata <= {it.tag, it.right, it.left, it.val, it.pos};
    do @(posedge clk); while (!in_tready);
    sb.note_request(it.req, it.pos, it.val, it.left, it.right, it.tag);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // loads give no answer, so a drain covers a load still zeroing counts
  task automatic wait_for_answers(input bit drain);
    in_tvalid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    if (drain) repeat (LOAD_DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  // result side
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 9);
      @(posedge clk);
      if (out_tvalid && out_tready)
        sb.check_answer(out_tdata[15:0], out_tdata[51:16], out_tuser, out_tdata[55:52]);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme positions and values, repeated values, reversed-range rejects
    send_item(load_item(0, 0));
    send_item(load_item(1, 4095));
    send_item(load_item(2, 4095));
    send_item(load_item(3, 1));
    send_item(load_item(4095, 2048));
    send_item(load_item(4094, 4095));
    send_item(query_item(4094, 4095, 16'hFFFF));
    send_item(query_item(4095, 4095, 0));
    send_item(load_item(4, 2048));
    send_item(load_item(5, 7));
    send_item(query_item(0, 3, $urandom_range(0, 65535)));
    send_item(query_item(1, 2, $urandom_range(0, 65535)));
    send_item(query_item(0, 0, $urandom_range(0, 65535)));
    send_item(query_item(2, 5, $urandom_range(0, 65535)));
    send_item(query_item(0, 5, $urandom_range(0, 65535)));
    send_item(query_item(3, 2, $urandom_range(0, 65535)));
    send_item(query_item(4095, 0, $urandom_range(0, 65535)));
    send_item(query_item(5, 5, $urandom_range(0, 65535)));
    send_item(query_item(4, 4, $urandom_range(0, 65535)));
    fill_top = 6;

    foreach (limit_plan[ph]) begin
      wait_for_answers(1'b1);
      write_limit(CFG_W'(limit_plan[ph]));
      steady = (ph == 4);
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) wait_for_answers(1'b0);
        send_item(pick_item());
      end
    end
    steady = 1'b0;

    wait_for_answers(1'b1);
    $display("covered %0d loads and %0d queries (%0d rejected), %0d answers checked",
             sb.loads_seen, sb.queries_seen, sb.rejects_seen, sb.answers_seen);
    $display("element_count went through %0d settings from 0 to 8191, loaded prefix %0d",
             $size(limit_plan), fill_top);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
sv/rpwe_pkg.sv
sv/rpwe_sum_unit.sv
sv/range_power_window_engine_core.sv
tb/range_power_window_engine_core_test.sv
